### src/ctks_pkg.sv
// ----------------------------------------------------------------------------
// ctks_pkg
// Shared constants and types for the top-k cosine similarity search block.
// ----------------------------------------------------------------------------
package ctks_pkg;

  localparam int DIM_MAX_DEF     = 1024;
  localparam int VECTORS_MAX_DEF = 65536;
  localparam int K_MAX_DEF       = 16;

  localparam int SCORE_W   = 16;
  localparam int IDX_W     = 16;
  localparam int ELEM_W    = 16;
  localparam int TOPCNT_W  = 5;
  localparam int VLEN_W    = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TOP_COUNT     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 1'b1;

  localparam logic KIND_QUERY    = 1'b0;
  localparam logic KIND_DATABASE = 1'b1;

  typedef struct packed {
    logic ins;
    logic shift;
  } ctks_ctl_t;

endpackage

### src/ctks_cell.sv
// ----------------------------------------------------------------------------
// ctks_cell
// One slot of the sorted best-score list; inserts or shifts with its neighbors.
// ----------------------------------------------------------------------------
module ctks_cell import ctks_pkg::*; (
  input  logic                      clk,
  input  ctks_ctl_t                 ctl,
  input  logic                      occ,
  input  logic signed [SCORE_W-1:0] new_score,
  input  logic [IDX_W-1:0]          new_index,
  input  logic signed [SCORE_W-1:0] prev_score,
  input  logic [IDX_W-1:0]          prev_index,
  input  logic                      prev_ge,
  input  logic signed [SCORE_W-1:0] next_score,
  input  logic [IDX_W-1:0]          next_index,
  output logic signed [SCORE_W-1:0] score_o,
  output logic [IDX_W-1:0]          index_o,
  output logic                      ge_o
);

  logic signed [SCORE_W-1:0] score_r;
  logic [IDX_W-1:0]          index_r;

  assign ge_o    = occ && (score_r >= new_score);
  assign score_o = score_r;
  assign index_o = index_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      score_r <= next_score;
      index_r <= next_index;
    end else if (ctl.ins && !ge_o) begin
      if (prev_ge) begin
        score_r <= new_score;
        index_r <= new_index;
      end else begin
        score_r <= prev_score;
        index_r <= prev_index;
      end
    end
  end

endmodule

### src/ctks_score.sv
// ----------------------------------------------------------------------------
// ctks_score
// Multi-cycle cosine score: shift-add products, then bit-serial root search.
// ----------------------------------------------------------------------------
module ctks_score import ctks_pkg::*; #(
  parameter int NW = 41
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start_i,
  input  logic signed [NW:0]        dot_i,
  input  logic [NW-1:0]             qn_i,
  input  logic [NW-1:0]             dn_i,
  output logic                      done_o,
  output logic signed [SCORE_W-1:0] score_o
);

  localparam int PW   = 2 * NW;
  localparam int CW   = 2 * NW + 34;
  localparam int CNTW = $clog2(NW + 1);
  localparam int BW   = $clog2(SCORE_W);

  localparam logic [1:0] SC_IDLE = 2'd0;
  localparam logic [1:0] SC_MUL  = 2'd1;
  localparam logic [1:0] SC_ADD  = 2'd2;
  localparam logic [1:0] SC_CMP  = 2'd3;

  logic [1:0]         st_r;
  logic [CNTW-1:0]    cnt_r;
  logic [BW-1:0]      bit_r;
  logic [PW-1:0]      dn_a_r, mag_a_r, p_r, r_r;
  logic [NW-1:0]      qn_b_r, mag_b_r;
  logic [CW-1:0]      s_r, u_r, pb_r, cand_r;
  logic [SCORE_W-1:0] m_r;
  logic               zero_r, neg_r, done_r;
  logic signed [SCORE_W-1:0] score_r;

  logic [PW-1:0]      p_add, r_add;
  logic [CW-1:0]      rsh, u_up;
  logic               fit;
  logic [SCORE_W-1:0] m_n;
  logic signed [SCORE_W:0] m_ext;
  logic [NW:0]        dot_neg;

  assign dot_neg = -dot_i;
  assign p_add   = qn_b_r[0] ? p_r + dn_a_r : p_r;
  assign r_add   = mag_b_r[0] ? r_r + mag_a_r : r_r;
  assign rsh     = CW'(r_r) << 30;
  assign fit     = cand_r <= rsh;
  assign u_up    = fit ? u_r + (pb_r << 1) : u_r;

  always_comb begin
    m_n = m_r;
    if (fit) begin
      m_n[bit_r] = 1'b1;
    end
  end

  assign m_ext = {1'b0, m_n};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= SC_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        SC_IDLE: begin
          if (start_i) begin
            st_r    <= SC_MUL;
            cnt_r   <= '0;
            p_r     <= '0;
            r_r     <= '0;
            dn_a_r  <= PW'(dn_i);
            qn_b_r  <= qn_i;
            mag_a_r <= dot_i[NW] ? PW'(dot_neg[NW-1:0]) : PW'(dot_i[NW-1:0]);
            mag_b_r <= dot_i[NW] ? dot_neg[NW-1:0] : dot_i[NW-1:0];
            neg_r   <= dot_i[NW];
            zero_r  <= (qn_i == '0) || (dn_i == '0);
          end
        end
        SC_MUL: begin
          p_r     <= p_add;
          r_r     <= r_add;
          dn_a_r  <= dn_a_r << 1;
          mag_a_r <= mag_a_r << 1;
          qn_b_r  <= qn_b_r >> 1;
          mag_b_r <= mag_b_r >> 1;
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r == CNTW'(NW - 1)) begin
            st_r  <= SC_ADD;
            s_r   <= '0;
            u_r   <= '0;
            pb_r  <= CW'(p_add) << (2 * (SCORE_W - 1));
            m_r   <= '0;
            bit_r <= BW'(SCORE_W - 1);
          end
        end
        SC_ADD: begin
          cand_r <= s_r + u_r + pb_r;
          st_r   <= SC_CMP;
        end
        SC_CMP: begin
          if (fit) begin
            s_r <= cand_r;
          end
          m_r  <= m_n;
          u_r  <= u_up >> 1;
          pb_r <= pb_r >> 2;
          if (bit_r == '0) begin
            st_r   <= SC_IDLE;
            done_r <= 1'b1;
            if (zero_r) begin
              score_r <= '0;
            end else if (neg_r) begin
              // root at or above one saturates to minus one
              if (m_n[SCORE_W-1]) begin
                score_r <= {1'b1, {(SCORE_W-1){1'b0}}};
              end else begin
                score_r <= SCORE_W'(-m_ext);
              end
            end else if (m_n[SCORE_W-1]) begin
              score_r <= {1'b0, {(SCORE_W-1){1'b1}}};
            end else begin
              score_r <= m_n;
            end
          end else begin
            bit_r <= bit_r - 1'b1;
            st_r  <= SC_ADD;
          end
        end
        default: st_r <= SC_IDLE;
      endcase
    end
  end

  assign done_o  = done_r;
  assign score_o = score_r;

endmodule

### src/cosine_topk_search.sv
// ----------------------------------------------------------------------------
// cosine_topk_search
// Streams a query and database vectors, ranks cosine scores, emits top-k.
// ----------------------------------------------------------------------------
// usage:
//   cfg_we/cfg_index/cfg_data write top_count (index 0) or vector_length
//   (index 1) while the block is idle.
//   in_* beats carry one vector element each; a query element at position 0
//   starts a new search. out_* beats carry the ranked indices, best first,
//   with out_last_match on the final one.
// throughput: one element per cycle inside a vector. the beat that closes a
//   database vector stalls input while its score passes the s1 and s2
//   registers, the serial multiplier over NW bits (NW = norm width, 41 at
//   the default dimension) and the bit-serial root search in ctks_score,
//   and is then inserted into the cell row.
// output: after the last score is done, the FSM passes ST_POST, then ST_EMIT shows the first index.
// on a closing beat with end_of_set, min(k, ranked) index beats follow, one
//   per cycle while out_stall is low; input is stalled until the last one.
// reset: synchronous, active low; clears list fill, counters, accumulators
//   and sets top_count to 1 and vector_length to 1024. query memory is not
//   cleared and must be loaded before database vectors arrive.
// ----------------------------------------------------------------------------
module cosine_topk_search import ctks_pkg::*; #(
  parameter int DIM_MAX     = DIM_MAX_DEF,
  parameter int VECTORS_MAX = VECTORS_MAX_DEF,
  parameter int K_MAX       = K_MAX_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_kind,
  input  logic signed [ELEM_W-1:0] in_element_value,
  input  logic                     in_end_of_set,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         out_match_index,
  output logic                     out_last_match
);

  localparam int LOGD = $clog2(DIM_MAX);
  localparam int PW   = (DIM_MAX > 1) ? LOGD : 1;
  localparam int LW   = $clog2(DIM_MAX + 1) + 1;
  localparam int NW   = 31 + LOGD;
  localparam int DW   = NW + 1;
  localparam int CNTW = $clog2(VECTORS_MAX + 1);
  localparam int KW   = $clog2(K_MAX + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_POST = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [TOPCNT_W-1:0] topcnt_r;
  logic [VLEN_W-1:0]   vlen_r;
  logic [1:0]          st_r;
  logic [PW-1:0]       pos_r;
  logic                end_r;
  logic [CNTW-1:0]     vcnt_r;
  logic [KW-1:0]       filled_r, remain_r;
  logic signed [DW-1:0] dot_r;
  logic [NW-1:0]       dn_r, qn_r;

  logic [ELEM_W-1:0]   qmem [DIM_MAX];
  logic signed [ELEM_W-1:0] q_rd_r;

  logic                s1_v_r, s1_kind_r, s1_clr_r, s1_cmp_r;
  logic signed [ELEM_W-1:0] s1_x_r;
  logic                s2_v_r, s2_kind_r, s2_clr_r, s2_cmp_r;
  logic signed [31:0]  s2_dp_r;
  logic [30:0]         s2_sq_r;

  logic                in_acc, out_acc, completes;
  logic [LW-1:0]       len_eff, pos_inc;
  logic [KW-1:0]       k_eff, n_emit;
  logic signed [31:0]  sq_full;
  logic signed [DW-1:0] dot_sum;
  logic [NW-1:0]       dn_sum;
  logic                sc_start, sc_done;
  logic signed [SCORE_W-1:0] sc_score;
  logic                do_ins;
  ctks_ctl_t           ctl;

  logic signed [SCORE_W-1:0] c_score [K_MAX];
  logic [IDX_W-1:0]          c_index [K_MAX];
  logic                      c_ge    [K_MAX];

  assign in_stall = (st_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = (st_r == ST_EMIT);
  assign out_acc  = out_valid && !out_stall;

  always_comb begin
    if (vlen_r == '0) begin
      len_eff = LW'(1);
    end else if (32'(vlen_r) > DIM_MAX) begin
      len_eff = LW'(DIM_MAX);
    end else begin
      len_eff = LW'(vlen_r);
    end
    if (topcnt_r == '0) begin
      k_eff = KW'(1);
    end else if (32'(topcnt_r) > K_MAX) begin
      k_eff = KW'(K_MAX);
    end else begin
      k_eff = KW'(topcnt_r);
    end
  end

  assign pos_inc   = LW'(pos_r) + LW'(1);
  assign completes = pos_inc >= len_eff;
  assign n_emit    = (filled_r < k_eff) ? filled_r : k_eff;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (in_kind == KIND_QUERY) begin
        qmem[pos_r] <= in_element_value;
      end
      q_rd_r <= qmem[pos_r];
    end
  end

  assign sq_full = s1_x_r * s1_x_r;

  always_ff @(posedge clk) begin
    s1_x_r    <= in_element_value;
    s1_kind_r <= in_kind;
    s1_clr_r  <= (in_kind == KIND_QUERY) && (pos_r == '0);
    s1_cmp_r  <= completes;
    s2_dp_r   <= s1_x_r * q_rd_r;
    s2_sq_r   <= sq_full[30:0];
    s2_kind_r <= s1_kind_r;
    s2_clr_r  <= s1_clr_r;
    s2_cmp_r  <= s1_cmp_r;
  end

  assign dot_sum  = dot_r + DW'(s2_dp_r);
  assign dn_sum   = dn_r + NW'(s2_sq_r);
  assign sc_start = s2_v_r && (s2_kind_r == KIND_DATABASE) && s2_cmp_r;
  assign do_ins   = (st_r == ST_WAIT) && sc_done && (32'(vcnt_r) < VECTORS_MAX);

  assign ctl.ins   = do_ins;
  assign ctl.shift = out_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      topcnt_r <= TOPCNT_W'(1);
      vlen_r   <= VLEN_W'(1024);
      st_r     <= ST_IDLE;
      pos_r    <= '0;
      end_r    <= 1'b0;
      vcnt_r   <= '0;
      filled_r <= '0;
      remain_r <= '0;
      dot_r    <= '0;
      dn_r     <= '0;
      qn_r     <= '0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TOP_COUNT:     topcnt_r <= cfg_data[TOPCNT_W-1:0];
          CFG_VECTOR_LENGTH: vlen_r   <= cfg_data[VLEN_W-1:0];
          default: ;
        endcase
      end

      s1_v_r <= in_acc;
      s2_v_r <= s1_v_r;

      if (in_acc) begin
        pos_r <= completes ? '0 : pos_inc[PW-1:0];
        if (in_kind == KIND_DATABASE && completes) begin
          st_r  <= ST_WAIT;
          end_r <= in_end_of_set;
        end
      end

      if (s2_v_r) begin
        if (s2_kind_r == KIND_QUERY) begin
          qn_r <= s2_clr_r ? NW'(s2_sq_r) : qn_r + NW'(s2_sq_r);
          if (s2_clr_r) begin
            vcnt_r   <= '0;
            filled_r <= '0;
          end
        end
        if (s2_cmp_r || (s2_kind_r == KIND_QUERY && s2_clr_r)) begin
          dot_r <= '0;
          dn_r  <= '0;
        end else if (s2_kind_r == KIND_DATABASE) begin
          dot_r <= dot_sum;
          dn_r  <= dn_sum;
        end
      end

      unique case (st_r)
        ST_IDLE: ;
        ST_WAIT: begin
          if (sc_done) begin
            if (do_ins) begin
              vcnt_r <= vcnt_r + 1'b1;
              if (32'(filled_r) < K_MAX) begin
                filled_r <= filled_r + 1'b1;
              end
            end
            st_r <= end_r ? ST_POST : ST_IDLE;
          end
        end
        ST_POST: begin
          remain_r <= n_emit;
          if (n_emit == '0) begin
            filled_r <= '0;
            vcnt_r   <= '0;
            st_r     <= ST_IDLE;
          end else begin
            st_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_acc) begin
            remain_r <= remain_r - 1'b1;
            if (remain_r == KW'(1)) begin
              filled_r <= '0;
              vcnt_r   <= '0;
              st_r     <= ST_IDLE;
            end
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  ctks_score #(
    .NW (NW)
  ) u_score (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (sc_start),
    .dot_i   (dot_sum),
    .qn_i    (qn_r),
    .dn_i    (dn_sum),
    .done_o  (sc_done),
    .score_o (sc_score)
  );

  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    logic signed [SCORE_W-1:0] prev_s, next_s;
    logic [IDX_W-1:0]          prev_i, next_i;
    logic                      prev_g;
    if (i == 0) begin : g_first
      assign prev_s = sc_score;
      assign prev_i = IDX_W'(vcnt_r);
      assign prev_g = 1'b1;
    end else begin : g_mid
      assign prev_s = c_score[i-1];
      assign prev_i = c_index[i-1];
      assign prev_g = c_ge[i-1];
    end
    if (i == K_MAX - 1) begin : g_last
      assign next_s = c_score[i];
      assign next_i = c_index[i];
    end else begin : g_inner
      assign next_s = c_score[i+1];
      assign next_i = c_index[i+1];
    end
    ctks_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (32'(filled_r) > i),
      .new_score  (sc_score),
      .new_index  (IDX_W'(vcnt_r)),
      .prev_score (prev_s),
      .prev_index (prev_i),
      .prev_ge    (prev_g),
      .next_score (next_s),
      .next_index (next_i),
      .score_o    (c_score[i]),
      .index_o    (c_index[i]),
      .ge_o       (c_ge[i])
    );
  end

  assign out_match_index = c_index[0];
  assign out_last_match  = (remain_r == KW'(1));

endmodule

### bench/cosine_topk_search_tb.sv
// ----------------------------------------------------------------------------
// cosine_topk_search_tb
// Self-checking bench for the top-k cosine search block. Streams queries and
// database vectors through the valid/stall channel, predicts the ranked
// indices with its own fixed-point scoring and sorted list, and checks every
// output beat in order. Runs directed corner cases, a vector-length clamp
// set, backpressure and random sets, with random idling on both sides.
// ----------------------------------------------------------------------------
module cosine_topk_search_tb;
  import ctks_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 1_000_000;
  localparam int RANDOM_BEATS = 60;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic             last;
  } match_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_kind = KIND_QUERY;
  logic signed [ELEM_W-1:0] in_element_value = '0;
  logic                     in_end_of_set = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [IDX_W-1:0]         out_match_index;
  logic                     out_last_match;

  // predictor state
  logic [ELEM_W-1:0]  query_mem [DIM_MAX_DEF];
  int                 query_loaded;
  int                 elem_pos;
  int                 vec_count;
  longint             dot_acc;
  longint             db_norm;
  longint             q_norm;
  int                 best_score [K_MAX_DEF];
  int                 best_idx [K_MAX_DEF];
  int                 best_fill;
  logic [TOPCNT_W-1:0] top_cfg;
  logic [VLEN_W-1:0]  len_cfg;

  match_t ranked_q[$];
  int     errors;
  int     beats_sent;
  int     matches_seen;
  int     cycles;
  bit     calm;
  int     hold_cycles;
  int     stall_left;

  cosine_topk_search i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    match_t m;
    if (rst_n && out_valid && !out_stall) begin
      matches_seen++;
      if (ranked_q.size() == 0) begin
        report_mismatch($sformatf("unexpected index beat %0d", out_match_index));
      end else begin
        m = ranked_q.pop_front();
        if (out_match_index !== m.idx)
          report_mismatch($sformatf("match_index %0d, want %0d", out_match_index, m.idx));
        if (out_last_match !== m.last)
          report_mismatch($sformatf("last_match %0b, want %0b", out_last_match, m.last));
      end
    end
  end

  function automatic int cos_q15(longint dot, longint qn, longint dn);
    logic [255:0] rhs, prod, t;
    longint mag;
    int lo, hi, mid;
    if (qn == 0 || dn == 0) return 0;
    mag = dot < 0 ? -dot : dot;
    rhs = (256'(mag) * 256'(mag)) << 30;
    prod = 256'(qn) * 256'(dn);
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = prod * 256'(mid) * 256'(mid);
      if (t <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (dot < 0) return -lo;
    return lo > 32767 ? 32767 : lo;
  endfunction

  function automatic void rank_insert(int score, int index);
    int p, i;
    p = 0;
    while (p < best_fill && best_score[p] >= score) p++;
    if (p >= K_MAX_DEF) return;
    i = best_fill < K_MAX_DEF ? best_fill : K_MAX_DEF - 1;
    for (; i > p; i--) begin
      best_score[i] = best_score[i-1];
      best_idx[i] = best_idx[i-1];
    end
    best_score[p] = score;
    best_idx[p] = index;
    if (best_fill < K_MAX_DEF) best_fill++;
  endfunction

  function automatic int eff_len();
    if (len_cfg == 0) return 1;
    return len_cfg > DIM_MAX_DEF ? DIM_MAX_DEF : int'(len_cfg);
  endfunction

  function automatic void clear_search();
    vec_count = 0;
    best_fill = 0;
    dot_acc = 0;
    db_norm = 0;
    q_norm = 0;
  endfunction

  function automatic void score_beat(logic kind, logic signed [ELEM_W-1:0] v, logic eos);
    int k, n;
    bit done;
    longint x, q;
    match_t m;
    k = top_cfg == 0 ? 1 : (top_cfg > K_MAX_DEF ? K_MAX_DEF : int'(top_cfg));
    done = elem_pos + 1 >= eff_len();
    x = v;
    if (kind == KIND_QUERY) begin
      if (elem_pos == 0) clear_search();
      query_mem[elem_pos] = v;
      q_norm += x * x;
    end else begin
      q = $signed(query_mem[elem_pos]);
      dot_acc += x * q;
      db_norm += x * x;
      if (done) begin
        if (vec_count < VECTORS_MAX_DEF) begin
          rank_insert(cos_q15(dot_acc, q_norm, db_norm), vec_count);
          vec_count++;
        end
        if (eos) begin
          n = best_fill < k ? best_fill : k;
          for (int i = 0; i < n; i++) begin
            m.idx = best_idx[i];
            m.last = (i + 1 == n);
            ranked_q.push_back(m);
          end
          best_fill = 0;
          vec_count = 0;
        end
      end
    end
    if (done) begin
      elem_pos = 0;
      dot_acc = 0;
      db_norm = 0;
    end else begin
      elem_pos++;
    end
  endfunction

  task automatic send_beat(input logic kind, input logic signed [ELEM_W-1:0] v,
                           input logic eos);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_element_value <= v;
    in_end_of_set <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    score_beat(kind, v, eos);
    beats_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (ranked_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // registers change only once the block has drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    in_valid <= 1'b0;
    repeat (3) @(posedge clk);
    while (in_stall || ranked_q.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TOP_COUNT) top_cfg = val[TOPCNT_W-1:0];
    else len_cfg = val[VLEN_W-1:0];
  endtask

  task automatic load_query(input int mode);
    int len;
    len = eff_len();
    for (int i = 0; i < len; i++)
      case (mode)
        0: send_beat(KIND_QUERY, 16'($urandom), 1'b0);
        1: send_beat(KIND_QUERY, i[0] ? 16'sh7fff : 16'sh8000, 1'b0);
        default: send_beat(KIND_QUERY, '0, 1'b0);
      endcase
    query_loaded = len;
  endtask

  function automatic logic signed [ELEM_W-1:0] pick_elem(int mode, int i);
    logic signed [ELEM_W-1:0] q;
    q = query_mem[i];
    case (mode)
      1: return q;
      2: return q == 16'sh8000 ? 16'sh7fff : -q;
      3: return '0;
      4: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // noisy adds stray end marks and mid-vector query beats
  task automatic send_vector(input int mode, input bit eos, input bit noisy);
    int len, r;
    len = eff_len();
    for (int i = 0; i < len; i++) begin
      r = noisy ? $urandom_range(0, 9) : 9;
      if (i > 0 && r == 0)
        send_beat(KIND_QUERY, 16'($urandom), 1'($urandom));
      else
        send_beat(KIND_DATABASE, pick_elem(mode, i),
                  (i == len - 1) ? eos : (r == 1));
    end
  endtask

  task automatic test_register_limits();
    write_reg(CFG_TOP_COUNT, 0);
    write_reg(CFG_VECTOR_LENGTH, 0);
    send_beat(KIND_QUERY, 16'sh7fff, 1'b1);
    query_loaded = 1;
    send_beat(KIND_DATABASE, 16'sh8000, 1'b0);
    send_beat(KIND_DATABASE, 16'sh7fff, 1'b1);
    send_beat(KIND_QUERY, '0, 1'b0);
    send_beat(KIND_DATABASE, 16'sh1234, 1'b1);
    settle();
  endtask

  task automatic test_corner_scores();
    write_reg(CFG_TOP_COUNT, 31);
    write_reg(CFG_VECTOR_LENGTH, 3);
    load_query(1);
    send_vector(1, 1'b0, 1'b0);
    send_vector(2, 1'b0, 1'b0);
    send_vector(3, 1'b0, 1'b0);
    send_vector(1, 1'b0, 1'b0);
    send_beat(KIND_DATABASE, 16'sh0100, 1'b1);
    send_beat(KIND_QUERY, 16'sh4000, 1'b1);
    send_beat(KIND_DATABASE, 16'sh8000, 1'b1);
    settle();
  endtask

  // clamped length keeps the vector open, a shorter length then closes it
  task automatic test_full_length();
    write_reg(CFG_TOP_COUNT, 16);
    write_reg(CFG_VECTOR_LENGTH, 2047);
    for (int i = 0; i < 6; i++) send_beat(KIND_QUERY, 16'($urandom), 1'b0);
    write_reg(CFG_VECTOR_LENGTH, 5);
    send_beat(KIND_QUERY, 16'($urandom), 1'b0);
    query_loaded = 5;
    send_vector(0, 1'b0, 1'b0);
    send_vector(4, 1'b0, 1'b0);
    send_vector(1, 1'b1, 1'b0);
    settle();
  endtask

  task automatic test_output_hold();
    write_reg(CFG_VECTOR_LENGTH, 2);
    load_query(0);
    for (int v = 0; v < 12; v++) begin
      if (v == 11) hold_cycles = 300;
      send_vector($urandom_range(0, 4), v == 11, 1'b0);
    end
    for (int v = 0; v < 3; v++) send_vector($urandom_range(0, 4), v == 2, 1'b0);
    settle();
  endtask

  task automatic random_set();
    int nvec;
    if ($urandom_range(0, 3) == 0) write_reg(CFG_TOP_COUNT, $urandom_range(0, 31));
    if ($urandom_range(0, 4) == 0) write_reg(CFG_VECTOR_LENGTH, $urandom_range(1, 6));
    if (query_loaded < eff_len() || $urandom_range(0, 2) == 0) load_query(0);
    nvec = $urandom_range(1, 6);
    for (int v = 0; v < nvec; v++)
      send_vector($urandom_range(0, 4), v == nvec - 1, $urandom_range(0, 9) == 0);
  endtask

  task automatic test_random_sets();
    int start;
    start = beats_sent;
    write_reg(CFG_VECTOR_LENGTH, 4);
    while (beats_sent - start < RANDOM_BEATS) begin
      random_set();
      if ($urandom_range(0, 3) == 0) settle();
    end
    settle();
    calm = 1'b1;
    for (int s = 0; s < 2; s++) random_set();
    settle();
  endtask

  initial begin
    top_cfg = 5'd1;
    len_cfg = 11'd1024;
    elem_pos = 0;
    query_loaded = 0;
    clear_search();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_limits();
    test_corner_scores();
    test_full_length();
    test_output_hold();
    test_random_sets();
    while (ranked_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
